>>> hdl/mfol_pkg.sv
// ----------------------------------------------------------------------------
// mfol_pkg
// Shared constants, types and the saturation table for the median-filtered
// dissolved oxygen block.
// ----------------------------------------------------------------------------
`default_nettype none

package mfol_pkg;

    localparam int WINDOW_DEPTH = 30;
    localparam int SAMPLE_BITS  = 12;

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

    // sorted positions of the two middle values (equal for an odd depth)
    localparam int K_LO = (WINDOW_DEPTH - 1) / 2;
    localparam int K_HI = WINDOW_DEPTH / 2;

    localparam int VREF_W  = 13;
    localparam int RANGE_W = 16;
    localparam int SVOLT_W = 16;
    localparam int TEMP_W  = 6;
    localparam int OUT_W   = 16;
    localparam int CFG_W   = 16;
    localparam int TAB_W   = 11;

    // median * vref * 10 fits SAMPLE_BITS + VREF_W + 4 bits
    localparam int PROD_W = SAMPLE_BITS + VREF_W + 4;
    localparam int DIVD_W = PROD_W + TAB_W;
    localparam int DCNT_W = $clog2(DIVD_W);

    localparam int TAB_LAST = 40;

    localparam logic [VREF_W-1:0]  VREF_RST  = VREF_W'(3300);
    localparam logic [RANGE_W-1:0] RANGE_RST = RANGE_W'(4096);
    localparam logic [SVOLT_W-1:0] SVOLT_RST = SVOLT_W'(11276);
    localparam logic [TEMP_W-1:0]  TEMP_RST  = TEMP_W'(25);

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    localparam logic [TAB_W-1:0] SAT_TABLE [0:TAB_LAST] = '{
        11'd1446, 11'd1422, 11'd1382, 11'd1344, 11'd1309,
        11'd1274, 11'd1242, 11'd1211, 11'd1181, 11'd1153,
        11'd1126, 11'd1101, 11'd1077, 11'd1053, 11'd1030,
        11'd1008, 11'd986,  11'd966,  11'd946,  11'd927,
        11'd908,  11'd890,  11'd873,  11'd857,  11'd841,
        11'd825,  11'd811,  11'd796,  11'd782,  11'd769,
        11'd756,  11'd743,  11'd730,  11'd718,  11'd707,
        11'd695,  11'd684,  11'd673,  11'd663,  11'd653,
        11'd641
    };

    typedef enum logic [1:0] {
        CFG_VREF  = 2'd0,
        CFG_RANGE = 2'd1,
        CFG_SVOLT = 2'd2,
        CFG_TEMP  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_EVAL = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MED,
        S_X10,
        S_DIV1_GO,
        S_DIV1_WAIT,
        S_MUL2,
        S_DIV2_GO,
        S_DIV2_WAIT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        R_IDLE,
        R_LOAD,
        R_SWEEP
    } t_rank_state;

    typedef struct packed {
        logic                   push;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   start;
    } t_ring_ctl;

    typedef struct packed {
        logic                   done;
        logic [SAMPLE_BITS-1:0] median;
    } t_ring_sts;

    typedef struct packed {
        logic               start;
        logic [DIVD_W-1:0]  dividend;
        logic [RANGE_W-1:0] divisor;
    } t_div_ctl;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quot;
    } t_div_sts;

    function automatic logic [TAB_W-1:0] sat_lookup(input logic [TEMP_W-1:0] temp);
        logic [TEMP_W-1:0] idx;
        idx = (temp > TEMP_W'(TAB_LAST)) ? TEMP_W'(TAB_LAST) : temp;
        return SAT_TABLE[idx];
    endfunction

endpackage

`default_nettype wire

>>> hdl/mfol_if.sv
// ----------------------------------------------------------------------------
// mfol_if
// Valid/ready channels of the oxygen block: input items, results, and
// register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfol_in_if import mfol_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   op;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output op, output sample, input ready);
    modport sink   (input valid, input op, input sample, output ready);
endinterface

interface mfol_out_if import mfol_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] avg_volt;
    logic [OUT_W-1:0] oxygen_level;

    modport source (output valid, output avg_volt, output oxygen_level, input ready);
    modport sink   (input valid, input avg_volt, input oxygen_level, output ready);
endinterface

interface mfol_cfg_if import mfol_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       index;
    logic [CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/mfol_ring.sv
// ----------------------------------------------------------------------------
// mfol_ring
// Sample ring with a rank-counting median search: one ring entry compared per cycle while sweeping.
// ----------------------------------------------------------------------------
`default_nettype none

module mfol_ring import mfol_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_ring_ctl i_ctl,
    output t_ring_sts  o_sts
);

    logic [SAMPLE_BITS-1:0] r_ring [WINDOW_DEPTH];
    logic [IDX_W-1:0]       r_wr_idx;

    t_rank_state            r_state, n_state;
    logic [IDX_W-1:0]       r_i, r_j;
    logic [SAMPLE_BITS-1:0] r_cand;
    logic [CNT_W-1:0]       r_lt, r_le;
    logic [SAMPLE_BITS-1:0] r_lo, r_hi;
    logic                   r_lo_ok, r_hi_ok;
    logic                   r_done;
    logic [SAMPLE_BITS-1:0] r_med;

    logic [IDX_W-1:0]       rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic                   last_j;
    logic [CNT_W-1:0]       n_lt, n_le;
    logic                   hit_lo, hit_hi, finish;
    logic [SAMPLE_BITS-1:0] lo_val, hi_val;
    logic [SAMPLE_BITS:0]   mid_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
            r_wr_idx <= '0;
        end else if (i_ctl.push) begin
            r_ring[r_wr_idx] <= i_ctl.sample;
            r_wr_idx <= (r_wr_idx == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
        end
    end

    assign rd_data = r_ring[rd_addr];
    assign last_j  = (r_j == IDX_W'(WINDOW_DEPTH - 1));
    assign n_lt    = r_lt + CNT_W'(rd_data < r_cand);
    assign n_le    = r_le + CNT_W'(rd_data <= r_cand);
    assign hit_lo  = (r_state == R_SWEEP) && last_j
                     && (n_lt <= CNT_W'(K_LO)) && (CNT_W'(K_LO) < n_le);
    assign hit_hi  = (r_state == R_SWEEP) && last_j
                     && (n_lt <= CNT_W'(K_HI)) && (CNT_W'(K_HI) < n_le);
    assign finish  = (r_state == R_SWEEP) && last_j
                     && (r_lo_ok || hit_lo) && (r_hi_ok || hit_hi);
    assign lo_val  = hit_lo ? r_cand : r_lo;
    assign hi_val  = hit_hi ? r_cand : r_hi;
    assign mid_sum = {1'b0, lo_val} + {1'b0, hi_val};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            R_IDLE:  if (i_ctl.start) n_state = R_LOAD;
            R_LOAD:  n_state = R_SWEEP;
            R_SWEEP: begin
                if (last_j) n_state = finish ? R_IDLE : R_LOAD;
            end
            default: n_state = R_IDLE;
        endcase
    end

    // outputs: single read port, candidate on load, sweep index otherwise
    always_comb begin
        unique case (r_state)
            R_LOAD:  rd_addr = r_i;
            default: rd_addr = r_j;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_done  <= 1'b0;
            r_lo_ok <= 1'b0;
            r_hi_ok <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= finish;
            unique case (r_state)
                R_IDLE: begin
                    r_i     <= '0;
                    r_lo_ok <= 1'b0;
                    r_hi_ok <= 1'b0;
                end
                R_LOAD: begin
                    r_cand <= rd_data;
                    r_j    <= '0;
                    r_lt   <= '0;
                    r_le   <= '0;
                end
                R_SWEEP: begin
                    r_lt <= n_lt;
                    r_le <= n_le;
                    r_j  <= r_j + 1'b1;
                    if (hit_lo) begin
                        r_lo    <= r_cand;
                        r_lo_ok <= 1'b1;
                    end
                    if (hit_hi) begin
                        r_hi    <= r_cand;
                        r_hi_ok <= 1'b1;
                    end
                    // advance to the next candidate
                    if (last_j) r_i <= r_i + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) r_med <= mid_sum[SAMPLE_BITS:1];
    end

    assign o_sts.done   = r_done;
    assign o_sts.median = r_med;

endmodule

`default_nettype wire

>>> hdl/mfol_div.sv
// ----------------------------------------------------------------------------
// mfol_div
// Restoring divider, one quotient bit per cycle, shared by both scalings.
// ----------------------------------------------------------------------------
`default_nettype none

module mfol_div import mfol_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_div_ctl i_ctl,
    output t_div_sts  o_sts
);

    logic                r_busy;
    logic                r_done;
    logic [DCNT_W-1:0]   r_cnt;
    logic [DIVD_W-1:0]   r_q;
    logic [RANGE_W-1:0]  r_rem;
    logic [RANGE_W-1:0]  r_dsr;

    logic [RANGE_W:0]    rem_sh;
    logic [RANGE_W:0]    rem_sub;
    logic                q_bit;

    assign rem_sh  = {r_rem, r_q[DIVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dsr};
    assign q_bit   = (rem_sh >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_q   <= i_ctl.dividend;
            r_dsr <= i_ctl.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= q_bit ? rem_sub[RANGE_W-1:0] : rem_sh[RANGE_W-1:0];
            r_q   <= {r_q[DIVD_W-2:0], q_bit};
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.quot = r_q;

endmodule

`default_nettype wire

>>> hdl/median_filtered_oxygen_level.sv
// ----------------------------------------------------------------------------
// median_filtered_oxygen_level
// Median filter over a ring of ADC samples, scaled to probe voltage and
// dissolved oxygen.
// ----------------------------------------------------------------------------
// A push item (op 0) is taken and writes the ring. An evaluate item (op 1)
// finds the median by ranking each ring entry against all others with one
// read port, trying at most WINDOW_DEPTH candidates, then runs two serial
// divisions on one shared divider. The input is not ready during an
// evaluation. The result waits in an output register, so pushes go on while
// it is not yet taken. Registers are written through the config channel,
// which is always ready; write it only while the block is idle.
`default_nettype none

module median_filtered_oxygen_level import mfol_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mfol_in_if.sink   i_in,
    mfol_out_if.source o_out,
    mfol_cfg_if.sink  i_cfg
);

    t_state             r_state, n_state;
    logic [VREF_W-1:0]  r_vref;
    logic [RANGE_W-1:0] r_range;
    logic [SVOLT_W-1:0] r_svolt;
    logic [TEMP_W-1:0]  r_temp;

    logic [DIVD_W-1:0]  r_acc;
    logic [PROD_W-1:0]  r_volt;
    logic [OUT_W-1:0]   r_avg, r_oxy;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_avg, r_out_oxy;

    t_ring_ctl ring_ctl;
    t_ring_sts ring_sts;
    t_div_ctl  div_ctl;
    t_div_sts  div_sts;

    logic in_ready;
    logic in_acc;
    logic out_load;
    logic sat_hi;

    mfol_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ring_ctl),
        .o_sts   (ring_sts)
    );

    mfol_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .o_sts   (div_sts)
    );

    assign in_acc = i_in.valid && in_ready;
    assign sat_hi = |div_sts.quot[DIVD_W-1:OUT_W];

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vref  <= VREF_RST;
            r_range <= RANGE_RST;
            r_svolt <= SVOLT_RST;
            r_temp  <= TEMP_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_VREF:  r_vref  <= i_cfg.data[VREF_W-1:0];
                CFG_RANGE: r_range <= i_cfg.data[RANGE_W-1:0];
                CFG_SVOLT: r_svolt <= i_cfg.data[SVOLT_W-1:0];
                CFG_TEMP:  r_temp  <= i_cfg.data[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (in_acc && (t_op'(i_in.op) == OP_EVAL)) n_state = S_MED;
            S_MED:       if (ring_sts.done) n_state = S_X10;
            S_X10:       n_state = S_DIV1_GO;
            S_DIV1_GO:   n_state = S_DIV1_WAIT;
            S_DIV1_WAIT: if (div_sts.done) n_state = S_MUL2;
            S_MUL2:      n_state = S_DIV2_GO;
            S_DIV2_GO:   n_state = S_DIV2_WAIT;
            S_DIV2_WAIT: if (div_sts.done) n_state = S_DONE;
            S_DONE:      if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        in_ready         = 1'b0;
        out_load         = 1'b0;
        ring_ctl.push    = 1'b0;
        ring_ctl.sample  = i_in.sample[SAMPLE_BITS-1:0];
        ring_ctl.start   = 1'b0;
        div_ctl.start    = 1'b0;
        div_ctl.dividend = r_acc;
        div_ctl.divisor  = r_range;
        unique case (r_state)
            S_IDLE: begin
                in_ready       = 1'b1;
                ring_ctl.push  = i_in.valid && (t_op'(i_in.op) == OP_PUSH);
                ring_ctl.start = i_in.valid && (t_op'(i_in.op) == OP_EVAL);
            end
            S_DIV1_GO: div_ctl.start = 1'b1;
            S_DIV2_GO: begin
                div_ctl.start   = 1'b1;
                div_ctl.divisor = r_svolt;
            end
            S_DONE: out_load = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_MED: begin
                if (ring_sts.done) r_acc <= DIVD_W'(ring_sts.median * r_vref);
            end
            S_X10: r_acc <= (r_acc << 3) + (r_acc << 1);
            S_DIV1_WAIT: begin
                if (div_sts.done) begin
                    r_volt <= div_sts.quot[PROD_W-1:0];
                    r_avg  <= (sat_hi || (r_range == '0)) ? OUT_MAX
                                                          : div_sts.quot[OUT_W-1:0];
                end
            end
            S_MUL2: r_acc <= DIVD_W'(sat_lookup(r_temp) * r_volt);
            S_DIV2_WAIT: begin
                if (div_sts.done) begin
                    r_oxy <= (sat_hi || (r_svolt == '0) || (r_range == '0))
                             ? OUT_MAX : div_sts.quot[OUT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // output register: hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_avg <= r_avg;
            r_out_oxy <= r_oxy;
        end
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.avg_volt     = r_out_avg;
    assign o_out.oxygen_level = r_out_oxy;

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the median-filtered oxygen block. Pushes ADC
// samples and evaluate items under random gaps and output stalls, predicts
// each reading from its own copy of the sample ring and registers, and
// compares every reading, in order, with the prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import mfol_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES  = 3_000_000;
    localparam int SETTLE_CYCLES = 1100;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [OUT_W-1:0] avg_volt;
        logic [OUT_W-1:0] oxygen_level;
    } t_reading;

    class oxygen_reading_model;
        logic [SAMPLE_BITS-1:0] ring [WINDOW_DEPTH];
        int unsigned            wr_pos;
        logic [VREF_W-1:0]      vref;
        logic [RANGE_W-1:0]     adc_range;
        logic [SVOLT_W-1:0]     sat_volt;
        logic [TEMP_W-1:0]      sat_temp;
        t_reading               pending_readings[$];
        int unsigned            n_checked;
        int unsigned            failures;

        function new();
            foreach (ring[i]) ring[i] = '0;
            wr_pos    = 0;
            vref      = VREF_W'(3300);
            adc_range = RANGE_W'(4096);
            sat_volt  = SVOLT_W'(11276);
            sat_temp  = TEMP_W'(25);
            n_checked = 0;
            failures  = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_VREF:  vref      = data[VREF_W-1:0];
                CFG_RANGE: adc_range = data[RANGE_W-1:0];
                CFG_SVOLT: sat_volt  = data[SVOLT_W-1:0];
                CFG_TEMP:  sat_temp  = data[TEMP_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [SAMPLE_BITS-1:0] ring_median();
            logic [SAMPLE_BITS-1:0] sorted [WINDOW_DEPTH];
            logic [SAMPLE_BITS-1:0] v;
            logic [SAMPLE_BITS:0]   pair_sum;
            int                     j;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                v = ring[i];
                j = i;
                while (j > 0 && sorted[j-1] > v) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = v;
            end
            if (WINDOW_DEPTH % 2 != 0)
                return sorted[(WINDOW_DEPTH - 1) / 2];
            pair_sum = {1'b0, sorted[WINDOW_DEPTH/2]} + {1'b0, sorted[WINDOW_DEPTH/2 - 1]};
            return pair_sum[SAMPLE_BITS:1];
        endfunction

        function t_reading predict_reading();
            t_reading    r;
            logic [63:0] volt;
            logic [63:0] oxy;
            int unsigned idx;
            if (adc_range == 0) begin
                r.avg_volt     = OUT_MAX;
                r.oxygen_level = OUT_MAX;
                return r;
            end
            volt = 64'(ring_median()) * 64'(vref) * 64'd10 / 64'(adc_range);
            r.avg_volt = (volt > 64'(OUT_MAX)) ? OUT_MAX : volt[OUT_W-1:0];
            // hot calibration: clamp the table index to the last entry
            idx = (sat_temp > TEMP_W'(TAB_LAST)) ? TAB_LAST : int'(sat_temp);
            if (sat_volt == 0) begin
                oxy = 64'(OUT_MAX);
            end else begin
                oxy = 64'(SAT_TABLE[idx]) * volt / 64'(sat_volt);
            end
            r.oxygen_level = (oxy > 64'(OUT_MAX)) ? OUT_MAX : oxy[OUT_W-1:0];
            return r;
        endfunction

        function void take_item(t_op op, logic [SAMPLE_BITS-1:0] smp);
            if (op == OP_PUSH) begin
                ring[wr_pos] = smp;
                wr_pos = (wr_pos + 1 >= WINDOW_DEPTH) ? 0 : wr_pos + 1;
            end else begin
                pending_readings.push_back(predict_reading());
            end
        endfunction

        function void check_reading(logic [OUT_W-1:0] avg, logic [OUT_W-1:0] oxy);
            t_reading exp_r;
            n_checked++;
            if (pending_readings.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("reading %0d unexpected: avg_volt %0d oxygen_level %0d",
                             n_checked, avg, oxy);
                return;
            end
            exp_r = pending_readings.pop_front();
            if (avg !== exp_r.avg_volt || oxy !== exp_r.oxygen_level) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("reading %0d mismatch: avg_volt exp %0d got %0d, %s %0d got %0d",
                             n_checked, exp_r.avg_volt, avg, "oxygen_level exp",
                             exp_r.oxygen_level, oxy);
            end
        endfunction

        function int unsigned outstanding();
            return pending_readings.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    mfol_in_if  in_if ();
    mfol_out_if out_if ();
    mfol_cfg_if cfg_if ();

    median_filtered_oxygen_level dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    oxygen_reading_model model;
    int unsigned         gap_pct;
    int unsigned         stall_pct;
    int                  drift_center;
    int unsigned         cycles = 0;

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            model.check_reading(out_if.avg_volt, out_if.oxygen_level);
    end

    // result side: random stall bursts
    initial begin
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int unsigned mode;
        int          v;
        mode = $urandom_range(0, 19);
        if (mode < 8)
            return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        if (mode < 10)
            return mode[0] ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
        if (mode < 12)
            return SAMPLE_BITS'($urandom_range(0, 15));
        // slowly wandering level, like a real probe
        if ($urandom_range(0, 15) == 0)
            drift_center = $urandom_range(0, SAMPLE_MAX);
        v = drift_center + int'($urandom_range(0, 128)) - 64;
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        return SAMPLE_BITS'(v);
    endfunction

    task automatic send_item(input t_op op, input logic [SAMPLE_BITS-1:0] smp);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.op     <= op;
        in_if.sample <= smp;
        do @(posedge i_clk); while (!in_if.ready);
        model.take_item(op, smp);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        model.write_reg(idx, data);
    endtask

    task automatic set_config(input int unsigned vref, input int unsigned adc_range,
                              input int unsigned sat_volt, input int unsigned sat_temp);
        write_reg(CFG_VREF,  CFG_W'(vref));
        write_reg(CFG_RANGE, CFG_W'(adc_range));
        write_reg(CFG_SVOLT, CFG_W'(sat_volt));
        write_reg(CFG_TEMP,  CFG_W'(sat_temp));
        cfg_if.valid <= 1'b0;
    endtask

    // drain all readings, then give the block time to finish any work
    task automatic settle();
        in_if.valid <= 1'b0;
        while (model.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_config();
        int unsigned vref;
        int unsigned adc_range;
        int unsigned sat_volt;
        int unsigned pick;
        pick = $urandom_range(0, 7);
        vref = (pick == 0) ? 8191 : (pick == 1) ? 1 : $urandom_range(1, 5000);
        pick = $urandom_range(0, 19);
        if (pick == 0)
            adc_range = 0;
        else if (pick < 3)
            adc_range = $urandom_range(1, 16);
        else if (pick == 3)
            adc_range = 65535;
        else
            adc_range = $urandom_range(1024, 16384);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            sat_volt = 65535;
        else if (pick == 1)
            sat_volt = $urandom_range(1, 64);
        else
            sat_volt = $urandom_range(2000, 50000);
        set_config(vref, adc_range, sat_volt, $urandom_range(0, 63));
    endtask

    // the caller drops valid through settle
    task automatic run_random(input int n_items);
        t_op op;
        for (int k = 0; k < n_items; k++) begin
            op = ($urandom_range(0, 4) == 0) ? OP_EVAL : OP_PUSH;
            send_item(op, pick_sample());
        end
    endtask

    initial begin
        model        = new();
        gap_pct      = 0;
        stall_pct    = 0;
        drift_center = SAMPLE_MAX / 2;
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.op     <= OP_PUSH;
        in_if.sample <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_VREF;
        cfg_if.data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty ring, then a split ring, then a majority of full-scale samples
        send_item(OP_EVAL, '0);
        repeat (15) send_item(OP_PUSH, SAMPLE_BITS'(SAMPLE_MAX));
        send_item(OP_EVAL, SAMPLE_BITS'(SAMPLE_MAX));
        send_item(OP_PUSH, SAMPLE_BITS'(SAMPLE_MAX));
        send_item(OP_EVAL, '0);
        settle();

        // saturate both outputs, hot calibration temperature
        set_config(8191, 1, 1, 63);
        send_item(OP_EVAL, '0);
        settle();
        // zero ADC range
        set_config(3300, 0, 11276, 25);
        send_item(OP_EVAL, '0);
        settle();
        // zero saturation voltage, last table entry
        set_config(5000, 65535, 0, 40);
        send_item(OP_EVAL, '0);
        settle();
        // zero reference, first table entry
        set_config(0, 4096, 50000, 0);
        send_item(OP_EVAL, '0);
        settle();

        set_config(3300, 4096, 11276, 25);
        gap_pct   = 10;
        stall_pct = 10;
        run_random(105);
        for (int ph = 0; ph < 3; ph++) begin
            settle();
            random_config();
            gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
            run_random(105);
        end
        settle();
        random_config();
        gap_pct   = 0;
        stall_pct = 0;
        run_random(105);

        settle();
        if (model.failures == 0 && model.outstanding() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
